// ===== src/svf_pkg.sv =====
// Shared types and constants for the state variable filter core.
// Holds the microcode word layout, datapath widths and register codes.
// No dependencies.
package svf_pkg;

    // fixed datapath widths
    localparam int COEF_W = 15;
    localparam int ACC_W  = 24;
    localparam int PROD_W = COEF_W + 1 + ACC_W;
    localparam int SUM_W  = PROD_W + 2;
    localparam int MODE_W = 2;
    localparam int CFG_IDX_W = 2;

    // sequencer program size
    localparam int NUM_STEPS = 5;
    localparam int STEP_W    = $clog2(NUM_STEPS);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TUNING  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DAMPING = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MODE    = 2'd2;

    // response select codes; the unused code falls back to lowpass
    localparam logic [MODE_W-1:0] MODE_LOW  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_BAND = 2'd1;
    localparam logic [MODE_W-1:0] MODE_HIGH = 2'd2;

    localparam logic [COEF_W-1:0] DAMPING_RESET = 15'd16384;

    typedef logic [1:0] t_alu_op;
    localparam t_alu_op ALU_NOP  = 2'd0;
    localparam t_alu_op ALU_LOW  = 2'd1;
    localparam t_alu_op ALU_HIGH = 2'd2;
    localparam t_alu_op ALU_BAND = 2'd3;

    typedef logic [1:0] t_cond;
    localparam t_cond COND_NEXT     = 2'd0;
    localparam t_cond COND_WAIT_IN  = 2'd1;
    localparam t_cond COND_WAIT_OUT = 2'd2;

    typedef struct packed {
        logic    load_x;
        logic    mul_en;
        logic    coef_q;
        logic    opd_high;
        t_alu_op alu;
        logic    out_wr;
        t_cond   cond;
    } t_ucode;

    typedef struct packed {
        t_ucode uc;
        logic   fire;
        logic   idle;
    } t_seq_ctl;

    localparam logic signed [SUM_W-1:0] ACC_MAX_X = SUM_W'(2 ** (ACC_W - 1) - 1);
    localparam logic signed [SUM_W-1:0] ACC_MIN_X = SUM_W'(-(2 ** (ACC_W - 1)));

    function automatic logic signed [ACC_W-1:0] f_sat_acc(input logic signed [SUM_W-1:0] v);
        logic signed [ACC_W-1:0] r;
        if (v > ACC_MAX_X) begin
            r = ACC_MAX_X[ACC_W-1:0];
        end else if (v < ACC_MIN_X) begin
            r = ACC_MIN_X[ACC_W-1:0];
        end else begin
            r = v[ACC_W-1:0];
        end
        return r;
    endfunction

endpackage

// ===== src/svf_sequencer.sv =====
// Microcode sequencer: step counter, control store and jump conditions.
// Depends on svf_pkg for the control word layout.
module svf_sequencer
    import svf_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  logic     i_out_free,
    output t_seq_ctl o_ctl
);

    localparam logic [STEP_W-1:0] ST_FETCH   = STEP_W'(0);
    localparam logic [STEP_W-1:0] ST_LOW     = STEP_W'(1);
    localparam logic [STEP_W-1:0] ST_HIGH    = STEP_W'(2);
    localparam logic [STEP_W-1:0] ST_BANDMUL = STEP_W'(3);
    localparam logic [STEP_W-1:0] ST_BAND    = STEP_W'(4);

    function automatic t_ucode f_rom(input logic [STEP_W-1:0] a);
        t_ucode w;
        w = '0;
        unique case (a)
            ST_FETCH: begin
                // take the sample and start f*band
                w.cond   = COND_WAIT_IN;
                w.load_x = 1'b1;
                w.mul_en = 1'b1;
            end
            ST_LOW: begin
                w.alu    = ALU_LOW;
                w.mul_en = 1'b1;
                w.coef_q = 1'b1;
            end
            ST_HIGH: begin
                w.alu = ALU_HIGH;
            end
            ST_BANDMUL: begin
                w.mul_en   = 1'b1;
                w.opd_high = 1'b1;
            end
            ST_BAND: begin
                w.cond   = COND_WAIT_OUT;
                w.alu    = ALU_BAND;
                w.out_wr = 1'b1;
            end
            default: begin
                w.cond = COND_WAIT_OUT;
            end
        endcase
        return w;
    endfunction

    logic [STEP_W-1:0] r_step;
    logic [STEP_W-1:0] n_step;
    t_ucode            w_uc;
    logic              w_fire;

    always_comb begin
        w_uc = f_rom(r_step);
        unique case (w_uc.cond)
            COND_WAIT_IN: begin
                w_fire = i_in_valid;
                n_step = w_fire ? r_step + STEP_W'(1) : r_step;
            end
            COND_WAIT_OUT: begin
                // hold at the last step until the result slot opens, then return
                w_fire = i_out_free;
                n_step = w_fire ? ST_FETCH : r_step;
            end
            default: begin
                w_fire = 1'b1;
                n_step = r_step + STEP_W'(1);
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= ST_FETCH;
        end else begin
            r_step <= n_step;
        end
    end

    assign o_ctl.uc   = w_uc;
    assign o_ctl.fire = w_fire;
    assign o_ctl.idle = (r_step == ST_FETCH);

    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_step == ST_FETCH && i_in_valid) |=> (r_step == ST_LOW))
        else $error("sequencer did not leave fetch after a request");

    a_hold_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_step == ST_FETCH && !i_in_valid) |=> (r_step == ST_FETCH))
        else $error("sequencer left fetch without a request");

    a_wait_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_step == ST_BAND && !i_out_free) |=> (r_step == ST_BAND))
        else $error("sequencer passed the result step while the output was full");

endmodule

// ===== src/svf_datapath.sv =====
// Filter datapath: shared coefficient multiplier, rounding, saturating adder,
// integrator registers and the output register. Depends on svf_pkg.
module svf_datapath
    import svf_pkg::*;
#(
    parameter int SAMPLE_WIDTH   = 16,
    parameter int COEF_FRAC_BITS = 14
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  t_seq_ctl                       i_ctl,
    input  logic signed [SAMPLE_WIDTH-1:0] i_sample_in,
    input  logic        [COEF_W-1:0]       i_tuning,
    input  logic        [COEF_W-1:0]       i_damping,
    input  logic        [MODE_W-1:0]       i_mode,
    input  logic                           i_out_stall,
    output logic                           o_out_valid,
    output logic signed [SAMPLE_WIDTH-1:0] o_sample_out,
    output logic                           o_out_free
);

    localparam logic signed [PROD_W-1:0] RND_HALF = PROD_W'(1) <<< (COEF_FRAC_BITS - 1);
    localparam logic signed [ACC_W-1:0]  SMP_MAX  =
        ACC_W'((64'sd1 <<< (SAMPLE_WIDTH - 1)) - 64'sd1);
    localparam logic signed [ACC_W-1:0]  SMP_MIN  = ~SMP_MAX;

    logic signed [SAMPLE_WIDTH-1:0] r_x;
    logic signed [PROD_W-1:0]       r_prod;
    logic signed [ACC_W-1:0]        r_low;
    logic signed [ACC_W-1:0]        r_band;
    logic signed [ACC_W-1:0]        r_high;
    logic                           r_out_vld;
    logic signed [SAMPLE_WIDTH-1:0] r_out_data;

    logic        [COEF_W-1:0]       w_coef;
    logic signed [COEF_W:0]         w_coef_s;
    logic signed [ACC_W-1:0]        w_opd;
    logic signed [PROD_W-1:0]       w_prod;
    logic signed [PROD_W-1:0]       w_rnd;
    logic signed [SUM_W-1:0]        w_rnd_x;
    logic signed [SUM_W-1:0]        w_alu;
    logic signed [ACC_W-1:0]        w_acc_sat;
    logic signed [ACC_W-1:0]        w_sel;
    logic signed [ACC_W-1:0]        w_sel_sat;
    t_ucode                         w_uc;
    logic                           w_go;

    assign w_uc = i_ctl.uc;
    assign w_go = i_ctl.fire;

    assign w_coef   = w_uc.coef_q ? i_damping : i_tuning;
    assign w_coef_s = {1'b0, w_coef};
    assign w_opd    = w_uc.opd_high ? r_high : r_band;
    assign w_prod   = w_coef_s * w_opd;

    // round half up to the sample LSB
    assign w_rnd   = (r_prod + RND_HALF) >>> COEF_FRAC_BITS;
    assign w_rnd_x = SUM_W'(w_rnd);

    always_comb begin
        unique case (w_uc.alu)
            ALU_LOW:  w_alu = SUM_W'(r_low) + w_rnd_x;
            ALU_HIGH: w_alu = SUM_W'(r_x) - SUM_W'(r_low) - w_rnd_x;
            ALU_BAND: w_alu = SUM_W'(r_band) + w_rnd_x;
            default:  w_alu = '0;
        endcase
    end

    assign w_acc_sat = f_sat_acc(w_alu);

    always_comb begin
        unique case (i_mode)
            MODE_BAND: w_sel = w_acc_sat;
            MODE_HIGH: w_sel = r_high;
            default:   w_sel = r_low;
        endcase
        if (w_sel > SMP_MAX) begin
            w_sel_sat = SMP_MAX;
        end else if (w_sel < SMP_MIN) begin
            w_sel_sat = SMP_MIN;
        end else begin
            w_sel_sat = w_sel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low     <= '0;
            r_band    <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (w_go && w_uc.alu == ALU_LOW) begin
                r_low <= w_acc_sat;
            end
            if (w_go && w_uc.alu == ALU_BAND) begin
                r_band <= w_acc_sat;
            end
            if (w_go && w_uc.out_wr) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_go && w_uc.load_x) begin
            r_x <= i_sample_in;
        end
        if (w_go && w_uc.mul_en) begin
            r_prod <= w_prod;
        end
        if (w_go && w_uc.alu == ALU_HIGH) begin
            r_high <= w_acc_sat;
        end
        if (w_go && w_uc.out_wr) begin
            r_out_data <= w_sel_sat[SAMPLE_WIDTH-1:0];
        end
    end

    assign o_out_valid  = r_out_vld;
    assign o_sample_out = r_out_data;
    assign o_out_free   = !r_out_vld || !i_out_stall;

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_go && w_uc.out_wr) |-> !(r_out_vld && i_out_stall))
        else $error("result register overwritten while its request was stalled");

endmodule

// ===== src/state_variable_filter_core.sv =====
// Top level of the state variable filter: configuration registers plus the
// microcode sequencer and datapath. Depends on svf_pkg, svf_sequencer, svf_datapath.
//
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+---------------------------
//  in      | input     | i_in_valid / o_in_stall  | i_sample_in
//  out     | output    | o_out_valid / i_out_stall| o_sample_out
//  cfg     | input     | i_cfg_valid / o_cfg_ready| i_cfg_index, i_cfg_data
//
// A sample passes through the five-step microprogram: the shared multiplier
// runs three dependent coefficient products in sequence, so a new sample is
// taken only once the sequencer is back at its fetch step.
// The result register is loaded on the last step; a new sample may be taken
// while an older result still waits. A stalled output holds the last step.
// Reset clears both integrators and restores the register defaults at once.
module state_variable_filter_core
    import svf_pkg::*;
#(
    parameter int SAMPLE_WIDTH   = 16,
    parameter int COEF_FRAC_BITS = 14
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic signed [SAMPLE_WIDTH-1:0] i_sample_in,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic signed [SAMPLE_WIDTH-1:0] o_sample_out,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic        [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic        [COEF_W-1:0]       i_cfg_data
);

    logic [COEF_W-1:0] r_tuning;
    logic [COEF_W-1:0] r_damping;
    logic [MODE_W-1:0] r_mode;
    t_seq_ctl          w_ctl;
    logic              w_out_free;

    assign o_cfg_ready = 1'b1;

    // unknown register index: drop the write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tuning  <= '0;
            r_damping <= DAMPING_RESET;
            r_mode    <= MODE_LOW;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_TUNING:  r_tuning  <= i_cfg_data;
                REG_DAMPING: r_damping <= i_cfg_data;
                REG_MODE:    r_mode    <= i_cfg_data[MODE_W-1:0];
                default: ;
            endcase
        end
    end

    svf_sequencer u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_out_free (w_out_free),
        .o_ctl      (w_ctl)
    );

    svf_datapath #(
        .SAMPLE_WIDTH   (SAMPLE_WIDTH),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (w_ctl),
        .i_sample_in  (i_sample_in),
        .i_tuning     (r_tuning),
        .i_damping    (r_damping),
        .i_mode       (r_mode),
        .i_out_stall  (i_out_stall),
        .o_out_valid  (o_out_valid),
        .o_sample_out (o_sample_out),
        .o_out_free   (w_out_free)
    );

    assign o_in_stall = !w_ctl.idle;

endmodule

// ===== sim/state_variable_filter_core_tb.sv =====
// Self-checking testbench for state_variable_filter_core: fixed-point filter
// prediction, random sample bursts under several coefficient settings, random stalls.
// Depends on svf_pkg and the state_variable_filter_core RTL.
`timescale 1ns / 1ps

module state_variable_filter_core_tb
    import svf_pkg::*;
();

    localparam int SAMPLE_W        = 16;
    localparam int FRAC_BITS       = 14;
    localparam int RAND_PHASES     = 10;
    localparam int ITEMS_PER_PHASE = 155;
    localparam int DRAIN_CYCLES    = 20;
    localparam int HOLD_CYCLES     = 400;
    localparam int CYCLE_LIMIT     = 1000000;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED  = 2'd3;
    localparam logic [MODE_W-1:0]    MODE_UNUSED = 2'd3;

    localparam longint ACC_HI = (longint'(1) << (ACC_W - 1)) - 1;
    localparam longint ACC_LO = -(longint'(1) << (ACC_W - 1));
    localparam longint OUT_HI = (longint'(1) << (SAMPLE_W - 1)) - 1;
    localparam longint OUT_LO = -(longint'(1) << (SAMPLE_W - 1));

    typedef enum logic [1:0] {PAT_NOISE, PAT_QUIET, PAT_RAIL, PAT_DC} t_pattern;

    logic                       i_clk       = 1'b0;
    logic                       i_rst_n     = 1'b0;
    logic                       i_in_valid  = 1'b0;
    logic                       o_in_stall;
    logic signed [SAMPLE_W-1:0] i_sample_in = '0;
    logic                       o_out_valid;
    logic                       i_out_stall = 1'b0;
    logic signed [SAMPLE_W-1:0] o_sample_out;
    logic                       i_cfg_valid = 1'b0;
    logic                       o_cfg_ready;
    logic [CFG_IDX_W-1:0]       i_cfg_index = '0;
    logic [COEF_W-1:0]          i_cfg_data  = '0;

    // predictor state and register copies
    logic signed [ACC_W-1:0] low_acc   = '0;
    logic signed [ACC_W-1:0] band_acc  = '0;
    logic [COEF_W-1:0]       tune_coef = '0;
    logic [COEF_W-1:0]       damp_coef = DAMPING_RESET;
    logic [MODE_W-1:0]       resp_mode = MODE_LOW;

    logic signed [SAMPLE_W-1:0] pending_samples[$];
    logic signed [SAMPLE_W-1:0] expected_out[$];

    int  queued_cnt   = 0;
    int  accepted_cnt = 0;
    int  results_seen = 0;
    int  mismatch_cnt = 0;
    int  cfg_sets     = 0;
    int  cycle_cnt    = 0;
    int  in_gap       = 0;
    int  out_gap      = 0;
    int  hold_cnt     = 0;
    bit  hold_req     = 1'b0;
    bit  hold_used    = 1'b0;
    bit  no_gaps      = 1'b0;
    bit  offering;

    state_variable_filter_core #(
        .SAMPLE_WIDTH  (SAMPLE_W),
        .COEF_FRAC_BITS(FRAC_BITS)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_sample_in (i_sample_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_sample_out(o_sample_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic longint clamp(input longint v, input longint lo, input longint hi);
        if (v > hi) return hi;
        if (v < lo) return lo;
        return v;
    endfunction

    // unsigned coefficient times value, rounded half up to the sample LSB
    function automatic longint coef_scale(input logic [COEF_W-1:0] c, input longint v);
        longint p;
        p = longint'(c) * v + (longint'(1) << (FRAC_BITS - 1));
        return p >>> FRAC_BITS;
    endfunction

    // one integrator update; returns the selected response
    function automatic logic signed [SAMPLE_W-1:0] filter_step(
        input logic signed [SAMPLE_W-1:0] x
    );
        longint lp, hp, bp, sel;
        lp = clamp(longint'(low_acc) + coef_scale(tune_coef, band_acc), ACC_LO, ACC_HI);
        hp = clamp(longint'(x) - lp - coef_scale(damp_coef, band_acc), ACC_LO, ACC_HI);
        bp = clamp(longint'(band_acc) + coef_scale(tune_coef, hp), ACC_LO, ACC_HI);
        low_acc  = lp[ACC_W-1:0];
        band_acc = bp[ACC_W-1:0];
        case (resp_mode)
            MODE_BAND: sel = bp;
            MODE_HIGH: sel = hp;
            default:   sel = lp;
        endcase
        sel = clamp(sel, OUT_LO, OUT_HI);
        return sel[SAMPLE_W-1:0];
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] pick_sample(
        input t_pattern pat, input logic signed [SAMPLE_W-1:0] level
    );
        int v;
        case (pat)
            PAT_QUIET: v = int'($urandom_range(0, 511)) - 256;
            PAT_RAIL: begin
                case ($urandom_range(0, 3))
                    0:       v = 32767;
                    1:       v = -32768;
                    2:       v = 32766;
                    default: v = -32767;
                endcase
            end
            PAT_DC:  v = level;
            default: v = $urandom;
        endcase
        return v[SAMPLE_W-1:0];
    endfunction

    function automatic void queue_sample(input logic signed [SAMPLE_W-1:0] s);
        pending_samples.push_back(s);
        queued_cnt++;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            REG_TUNING:  tune_coef = val;
            REG_DAMPING: damp_coef = val;
            REG_MODE:    resp_mode = val[MODE_W-1:0];
            default:     ;
        endcase
    endtask

    // the unused index is written too and must leave everything alone
    task automatic configure(input logic [COEF_W-1:0] tune, input logic [COEF_W-1:0] damp,
                             input logic [MODE_W-1:0] mode);
        write_reg(REG_TUNING, tune);
        write_reg(REG_UNUSED, COEF_W'($urandom));
        write_reg(REG_DAMPING, damp);
        write_reg(REG_MODE, {(COEF_W - MODE_W)'($urandom), mode});
        i_cfg_valid <= 1'b0;
        cfg_sets++;
    endtask

    task automatic wait_drained();
        @(posedge i_clk);
        while (results_seen < queued_cnt || expected_out.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // sample driver
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            offering = i_in_valid;
            if (i_in_valid && !o_in_stall) begin
                expected_out.push_back(filter_step(i_sample_in));
                accepted_cnt++;
                offering = 1'b0;
            end
            if (!offering) begin
                if (in_gap > 0) begin
                    in_gap--;
                end else if (pending_samples.size() != 0) begin
                    i_sample_in <= pending_samples.pop_front();
                    offering = 1'b1;
                    in_gap = no_gaps ? 0 : pick_gap();
                end
            end
            i_in_valid <= offering;
        end
    end

    // long output hold-off, armed once from the stimulus sequence
    always @(posedge i_clk) begin
        if (hold_cnt != 0) begin
            hold_cnt <= hold_cnt - 1;
        end else if (hold_req && !hold_used) begin
            hold_cnt  <= HOLD_CYCLES;
            hold_used <= 1'b1;
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                results_seen++;
                if (expected_out.size() == 0) begin
                    $display("%0t ERROR: result with none expected, expected none actual %0d",
                             $time, o_sample_out);
                    mismatch_cnt++;
                end else if (o_sample_out !== expected_out[0]) begin
                    $display("%0t ERROR: sample_out expected %0d actual %0d",
                             $time, expected_out.pop_front(), o_sample_out);
                    mismatch_cnt++;
                end else begin
                    void'(expected_out.pop_front());
                end
            end
            if (hold_cnt != 0) begin
                i_out_stall <= 1'b1;
            end else if (out_gap > 0) begin
                out_gap--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
                out_gap = no_gaps ? 0 : pick_gap();
            end
        end
    end

    initial begin
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        int                         ph, k, n, burst;
        t_pattern                   pat;
        logic signed [SAMPLE_W-1:0] level;
        logic [COEF_W-1:0]          tune, damp;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: zero tuning keeps the lowpass output at rest
        queue_sample(16'sh7fff);
        queue_sample(16'sh8000);
        queue_sample(16'sh0000);
        queue_sample(16'sh0001);
        queue_sample(16'shffff);
        wait_drained();

        // full tuning, no damping: drive both rails into saturation
        configure(15'h7fff, 15'h0000, MODE_HIGH);
        repeat (3) queue_sample(16'sh8000);
        repeat (3) queue_sample(16'sh7fff);
        wait_drained();

        configure(15'h4000, 15'h7fff, MODE_BAND);
        queue_sample(16'sh7fff);
        queue_sample(16'sh8000);
        queue_sample(16'sh5555);
        queue_sample(16'shaaaa);
        queue_sample(16'sh0000);
        wait_drained();

        // unused mode code falls back to lowpass
        configure(15'h1000, 15'h2000, MODE_UNUSED);
        queue_sample(16'sh4000);
        queue_sample(16'sh4000);
        queue_sample(16'shc000);
        queue_sample(16'sh7fff);
        queue_sample(16'sh8000);
        wait_drained();

        for (ph = 0; ph < RAND_PHASES; ph++) begin
            case (ph)
                0: configure(15'h0000, 15'h7fff, MODE_LOW);
                1: configure(15'h7fff, 15'h0000, MODE_BAND);
                2: configure(15'h7fff, 15'h7fff, MODE_HIGH);
                default: begin
                    tune = ($urandom_range(0, 3) == 0) ? COEF_W'($urandom)
                                                       : COEF_W'($urandom_range(64, 12000));
                    damp = ($urandom_range(0, 3) == 0) ? COEF_W'($urandom)
                                                       : COEF_W'($urandom_range(2000, 32767));
                    configure(tune, damp, MODE_W'($urandom_range(0, 3)));
                end
            endcase
            no_gaps <= (ph % 4 == 3);
            if (ph == 4) hold_req <= 1'b1;
            n = 0;
            while (n < ITEMS_PER_PHASE) begin
                burst = $urandom_range(8, 40);
                pat   = t_pattern'(2'($urandom_range(0, 3)));
                level = SAMPLE_W'($urandom);
                for (k = 0; k < burst && n < ITEMS_PER_PHASE; k++) begin
                    queue_sample(pick_sample(pat, level));
                    n++;
                end
            end
            wait_drained();
        end

        if (expected_out.size() != 0) mismatch_cnt++;
        $display("Covered %0d samples over %0d coefficient settings, %0d outputs checked.",
                 accepted_cnt, cfg_sets, results_seen);
        $display("Included rail saturation, all response codes and a long output hold.");
        if (mismatch_cnt == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
